// ===== rtl/jetc_pkg.sv =====
// jetc_pkg: shared constants, types and helpers of the julia escape time colorizer
// no dependencies; imported by every module of the block
`default_nettype none

package jetc_pkg;

  // number formats
  localparam int FRAC_BITS    = 28;
  localparam int PALETTE_SIZE = 256;
  localparam int ESCAPE_LIMIT = 10000;

  localparam int PT_W    = 32;
  localparam int TAG_W   = 20;
  localparam int CNT_W   = 8;
  localparam int COLOR_W = 24;
  localparam int CH_W    = 8;
  localparam int NUM_CH  = 3;
  localparam int REG_W   = 32;
  localparam int REG_IDX_W = 3;

  // orbit state: |z| stays below the escape bound plus |k| while iterating
  localparam int ST_W   = ((FRAC_BITS + 14 > PT_W - 1) ? FRAC_BITS + 14 : PT_W - 1) + 2;
  localparam int MAG_W  = ST_W - 1;
  localparam int HALF_W = (MAG_W + 1) / 2;
  localparam int PP_W   = 2 * HALF_W;
  localparam int ACC_W  = 4 * HALF_W;
  localparam int SQ_W   = ACC_W - FRAC_BITS;

  localparam logic [SQ_W:0] ESC_BOUND = (SQ_W + 1)'(ESCAPE_LIMIT) << FRAC_BITS;

  // gradient divider
  localparam int NUM_W     = 2 * CH_W;
  localparam int DIV_STEPS = NUM_W;

  // iteration limit clamp
  localparam logic [CNT_W-1:0] LIM_MIN = CNT_W'(2);
  localparam logic [CNT_W-1:0] LIM_MAX =
    CNT_W'((PALETTE_SIZE - 1 > (1 << CNT_W) - 1) ? (1 << CNT_W) - 1 : PALETTE_SIZE - 1);

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_JULIA_RE    = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_JULIA_IM    = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_MAX_ITER    = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_COLOR_START = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_COLOR_END   = REG_IDX_W'(4);

  // register reset values
  localparam logic [PT_W-1:0]    JULIA_RE_RST    = PT_W'(93952410);
  localparam logic [PT_W-1:0]    JULIA_IM_RST    = PT_W'(120795955);
  localparam logic [CNT_W-1:0]   MAX_ITER_RST    = CNT_W'(50);
  localparam logic [COLOR_W-1:0] COLOR_START_RST = COLOR_W'(24'hFF0000);
  localparam logic [COLOR_W-1:0] COLOR_END_RST   = COLOR_W'(24'h0000FF);

  // partial product codes: x half in bit 1, y half in bit 0
  localparam logic [1:0] MUL_LL = 2'd0;
  localparam logic [1:0] MUL_LH = 2'd1;
  localparam logic [1:0] MUL_HL = 2'd2;
  localparam logic [1:0] MUL_HH = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       prep;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       acc_en;
    logic       update;
    logic       blend;
    logic       div_step;
    logic       res_load;
  } jetc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic at_limit;
    logic escape;
  } jetc_sts_t;

  // effective iteration limit
  function automatic logic [CNT_W-1:0] clamp_limit(logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v < LIM_MIN) begin
      r = LIM_MIN;
    end else if (v > LIM_MAX) begin
      r = LIM_MAX;
    end
    return r;
  endfunction

  // sign extension of a point coordinate to the orbit width
  function automatic logic [ST_W-1:0] sext_pt(logic [PT_W-1:0] v);
    return {{(ST_W - PT_W){v[PT_W-1]}}, v};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/jetc_div.sv =====
// jetc_div: restoring divider lane, one quotient bit per step
// depends on jetc_pkg for the numerator and channel widths
`default_nettype none

module jetc_div
  import jetc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             load_i,
  input  wire logic             step_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [CH_W-1:0]  den_i,
  output logic      [CH_W-1:0]  quot_o
);

  logic [CH_W-1:0]  rem_q;
  logic [NUM_W-1:0] quo_q;
  logic [CH_W-1:0]  den_q;
  logic [CH_W:0]    rem_sh;
  logic [CH_W+1:0]  diff;
  logic             fits;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh = {rem_q, quo_q[NUM_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_q};
    fits   = !diff[CH_W+1];
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (step_i) begin
      rem_q <= fits ? diff[CH_W-1:0] : rem_sh[CH_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  // gradient value never exceeds one channel
  assign quot_o = quo_q[CH_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/jetc_dp.sv =====
// jetc_dp: orbit registers, three shared-step multipliers, escape test, gradient lanes
// depends on jetc_pkg and instantiates jetc_div for each color channel
`default_nettype none

module jetc_dp
  import jetc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire jetc_cmd_t           cmd_i,
  output jetc_sts_t                sts_o,
  input  wire logic [PT_W-1:0]     point_re_i,
  input  wire logic [PT_W-1:0]     point_im_i,
  input  wire logic [TAG_W-1:0]    pixel_index_i,
  input  wire logic [PT_W-1:0]     julia_re_i,
  input  wire logic [PT_W-1:0]     julia_im_i,
  input  wire logic [CNT_W-1:0]    limit_i,
  input  wire logic [COLOR_W-1:0]  color_start_i,
  input  wire logic [COLOR_W-1:0]  color_end_i,
  output logic      [TAG_W-1:0]    pixel_tag_o,
  output logic      [CNT_W-1:0]    iterations_o,
  output logic      [CH_W-1:0]     red_o,
  output logic      [CH_W-1:0]     green_o,
  output logic      [CH_W-1:0]     blue_o
);

  logic [ST_W-1:0]  re_q, im_q;
  logic [CNT_W-1:0] n_q, lim_q;
  logic [TAG_W-1:0] tag_q;
  logic [MAG_W-1:0] ma_q, mb_q;
  logic             neg_q;
  logic [1:0]       sel_q;
  logic [PP_W-1:0]  pa_q, pb_q, pc_q;
  logic [ACC_W-1:0] acc_a_q, acc_b_q, acc_c_q;

  logic [MAG_W-1:0]  ma, mb;
  logic [PP_W-1:0]   ma_ext, mb_ext;
  logic [HALF_W-1:0] ax, ay, bx, by;
  logic [SQ_W-1:0]   sq_a, sq_b, sq_c;
  logic [ST_W-1:0]   ab2, xprod, re_new, im_new;
  logic [CNT_W-1:0]  den, wgt;
  logic [CH_W-1:0]   quot [NUM_CH];
  logic              at_limit;

  // partial product placed at its weight
  function automatic logic [ACC_W-1:0] place_pp(logic [PP_W-1:0] pp, logic [1:0] sel);
    logic [ACC_W-1:0] r;
    r = ACC_W'(pp);
    case (sel)
      MUL_LL:         r = ACC_W'(pp);
      MUL_LH, MUL_HL: r = ACC_W'(pp) << HALF_W;
      MUL_HH:         r = ACC_W'(pp) << (2 * HALF_W);
      default:        r = ACC_W'(pp);
    endcase
    return r;
  endfunction

  // magnitudes of the current orbit point
  always_comb begin
    ma = re_q[ST_W-1] ? MAG_W'(-re_q) : re_q[MAG_W-1:0];
    mb = im_q[ST_W-1] ? MAG_W'(-im_q) : im_q[MAG_W-1:0];
  end

  // operand halves for the current partial product
  always_comb begin
    ma_ext = PP_W'(ma_q);
    mb_ext = PP_W'(mb_q);
    ax = cmd_i.mul_sel[1] ? ma_ext[HALF_W +: HALF_W] : ma_ext[0 +: HALF_W];
    ay = cmd_i.mul_sel[0] ? ma_ext[HALF_W +: HALF_W] : ma_ext[0 +: HALF_W];
    bx = cmd_i.mul_sel[1] ? mb_ext[HALF_W +: HALF_W] : mb_ext[0 +: HALF_W];
    by = cmd_i.mul_sel[0] ? mb_ext[HALF_W +: HALF_W] : mb_ext[0 +: HALF_W];
  end

  // escape test and next orbit point
  always_comb begin
    sq_a   = acc_a_q[ACC_W-1:FRAC_BITS];
    sq_b   = acc_b_q[ACC_W-1:FRAC_BITS];
    sq_c   = acc_c_q[ACC_W-1:FRAC_BITS];
    ab2    = {sq_c[ST_W-2:0], 1'b0};
    xprod  = neg_q ? -ab2 : ab2;
    re_new = sq_a[ST_W-1:0] - sq_b[ST_W-1:0] + sext_pt(julia_re_i);
    im_new = xprod + sext_pt(julia_im_i);
    at_limit = (n_q == lim_q);
  end

  assign sts_o.at_limit = at_limit;
  assign sts_o.escape   = ({1'b0, sq_a} + {1'b0, sq_b}) > ESC_BOUND;

  // orbit and iteration registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      re_q  <= sext_pt(point_re_i);
      im_q  <= sext_pt(point_im_i);
      n_q   <= '0;
      lim_q <= limit_i;
      tag_q <= pixel_index_i;
    end else if (cmd_i.update) begin
      re_q <= re_new;
      im_q <= im_new;
      n_q  <= n_q + CNT_W'(1);
    end
  end

  // magnitude capture ahead of the multiply sweep
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      ma_q  <= ma;
      mb_q  <= mb;
      neg_q <= re_q[ST_W-1] ^ im_q[ST_W-1];
    end
  end

  // partial products, registered before accumulation
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      pa_q  <= ax * ay;
      pb_q  <= bx * by;
      pc_q  <= ax * by;
      sel_q <= cmd_i.mul_sel;
    end
  end

  // accumulators for re^2, im^2 and re*im
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      acc_a_q <= '0;
      acc_b_q <= '0;
      acc_c_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_a_q <= acc_a_q + place_pp(pa_q, sel_q);
      acc_b_q <= acc_b_q + place_pp(pb_q, sel_q);
      acc_c_q <= acc_c_q + place_pp(pc_q, sel_q);
    end
  end

  // gradient weights
  always_comb begin
    den = lim_q - CNT_W'(1);
    wgt = den - n_q;
  end

  // one divider lane per channel, blue in lane 0
  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
    logic [NUM_W-1:0] num;
    always_comb begin
      num = NUM_W'(color_start_i[CH_W*ch +: CH_W]) * NUM_W'(wgt)
          + NUM_W'(color_end_i[CH_W*ch +: CH_W]) * NUM_W'(n_q);
    end
    jetc_div u_div (
      .clk_i  (clk_i),
      .load_i (cmd_i.blend),
      .step_i (cmd_i.div_step),
      .num_i  (num),
      .den_i  (den),
      .quot_o (quot[ch])
    );
  end

  // result registers, black when the orbit never escaped
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      pixel_tag_o  <= tag_q;
      iterations_o <= n_q;
      red_o        <= at_limit ? '0 : quot[2];
      green_o      <= at_limit ? '0 : quot[1];
      blue_o       <= at_limit ? '0 : quot[0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jetc_ctrl.sv =====
// jetc_ctrl: sequencer for one point, from request to result strobe
// depends on jetc_pkg for the command and status structs
`default_nettype none

module jetc_ctrl
  import jetc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire jetc_sts_t sts_i,
  output jetc_cmd_t      cmd_o,
  output logic           busy_o,
  output logic           done_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_BLEND  = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  localparam int SC_W = $clog2(DIV_STEPS);
  localparam logic [SC_W-1:0] MUL_LAST = SC_W'(4);
  localparam logic [SC_W-1:0] DIV_LAST = SC_W'(DIV_STEPS - 1);

  logic [2:0]      state_q, state_d;
  logic [SC_W-1:0] cnt_q, cnt_d;

  // next state and commands
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.at_limit) begin
          state_d = S_FIN;
        end else begin
          cmd_o.prep = 1'b1;
          cnt_d      = '0;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_en  = (cnt_q != MUL_LAST);
        cmd_o.mul_sel = cnt_q[1:0];
        cmd_o.acc_en  = (cnt_q != '0);
        cnt_d         = cnt_q + SC_W'(1);
        if (cnt_q == MUL_LAST) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (sts_i.escape) begin
          state_d = S_BLEND;
        end else begin
          cmd_o.update = 1'b1;
          state_d      = S_CHECK;
        end
      end
      S_BLEND: begin
        cmd_o.blend = 1'b1;
        cnt_d       = '0;
        state_d     = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + SC_W'(1);
        if (cnt_q == DIV_LAST) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.res_load = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

`default_nettype wire

// ===== rtl/julia_escape_time_colorizer_top.sv =====
// julia_escape_time_colorizer_top: config registers, controller and datapath
// depends on jetc_pkg, jetc_ctrl and jetc_dp
`default_nettype none

// Julia set escape time colorizer. A request (start high while busy is low) takes one point
// in signed Q4.28 and a pixel tag; the point is iterated z = z*z + k until |z|^2 passes 10000
// or the clamped limit M is reached, and one result is shown with done_o high for exactly one
// cycle; it cannot be held off, so the receiver must take it then. Every iteration is paced by
// the four-step sweep of the shared 22x22 multipliers (three of them, for re^2, im^2 and re*im)
// plus magnitude capture and update. An escaping point is colored by the 16-step gradient
// divider before its result; one that never escapes shows it once M steps are done. busy stays
// high up to and including the result cycle, so the next request can be taken in the cycle
// after it. Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user may
// change them only while idle, which the block itself does not enforce.
module julia_escape_time_colorizer_top
  import jetc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic signed [PT_W-1:0] point_re_i,
  input  wire logic signed [PT_W-1:0] point_im_i,
  input  wire logic [TAG_W-1:0]     pixel_index_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [REG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [REG_W-1:0]     cfg_wdata_i,
  output logic                      done_o,
  output logic [TAG_W-1:0]          pixel_tag_o,
  output logic [CNT_W-1:0]          iterations_o,
  output logic [CH_W-1:0]           red_o,
  output logic [CH_W-1:0]           green_o,
  output logic [CH_W-1:0]           blue_o
);

  logic [PT_W-1:0]    julia_re_q, julia_im_q;
  logic [CNT_W-1:0]   max_iter_q;
  logic [COLOR_W-1:0] color_start_q, color_end_q;
  logic [CNT_W-1:0]   limit;
  jetc_cmd_t          cmd;
  jetc_sts_t          sts;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      julia_re_q    <= JULIA_RE_RST;
      julia_im_q    <= JULIA_IM_RST;
      max_iter_q    <= MAX_ITER_RST;
      color_start_q <= COLOR_START_RST;
      color_end_q   <= COLOR_END_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_JULIA_RE:    julia_re_q    <= cfg_wdata_i[PT_W-1:0];
        REG_JULIA_IM:    julia_im_q    <= cfg_wdata_i[PT_W-1:0];
        REG_MAX_ITER:    max_iter_q    <= cfg_wdata_i[CNT_W-1:0];
        REG_COLOR_START: color_start_q <= cfg_wdata_i[COLOR_W-1:0];
        REG_COLOR_END:   color_end_q   <= cfg_wdata_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // effective iteration limit
  assign limit = clamp_limit(max_iter_q);

  jetc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  jetc_dp u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .point_re_i    (point_re_i),
    .point_im_i    (point_im_i),
    .pixel_index_i (pixel_index_i),
    .julia_re_i    (julia_re_q),
    .julia_im_i    (julia_im_q),
    .limit_i       (limit),
    .color_start_i (color_start_q),
    .color_end_i   (color_end_q),
    .pixel_tag_o   (pixel_tag_o),
    .iterations_o  (iterations_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o)
  );

  // a taken request keeps the block busy
  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // result strobe lasts a single cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // step count never passes the limit
  a_iter_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (iterations_o <= limit))
    else $error("iteration count above limit");

  // points that never escape come out black
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (iterations_o == limit)) |-> (red_o == '0 && green_o == '0 && blue_o == '0))
    else $error("non-escaping point not black");

endmodule

`default_nettype wire
